### rtl/parallel_biquad_equalizer_q15_macros.svh
// Assertion macros used by the equaliser's checker file.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef PARALLEL_BIQUAD_EQUALIZER_Q15_MACROS_SVH
`define PARALLEL_BIQUAD_EQUALIZER_Q15_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PBEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pbeq_pkg.sv
// Shared types, constants and the microprogram of the biquad equaliser.
// Depends on nothing; used by the sequencer, the datapath and the top level.
package pbeq_pkg;

  localparam int CFG_REGS  = 4;
  localparam int CFG_BANDS = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;
  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 34;
  localparam int SAT_SHIFT = 13;
  localparam int STEP_W    = 4;

  // Saturation bounds (the Q1.28 range) of the Q6.28 accumulator.
  localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-28){1'b0}}, 28'hFFF_FFFF};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-28){1'b1}}, 28'h000_0000};

  localparam logic [STEP_W-1:0] STEP_BAND_START = STEP_W'(1);

  typedef logic [CFG_REGS-1:0][CFG_W-1:0] cfg_bank_t;

  typedef enum logic [2:0] {
    OP_INIT, OP_MAC, OP_SAT, OP_GAIN, OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    SRC_X, SRC_X1, SRC_X2, SRC_Y1, SRC_Y2, SRC_YN
  } src_t;

  typedef enum logic [2:0] {
    C_B0, C_B1, C_B2, C_A1, C_A2, C_GAIN
  } csel_t;

  typedef struct packed {
    op_t               op;
    src_t              src;
    csel_t             coef;
    logic              first;   // load the band accumulator instead of adding
    logic              loop;    // jump to target while bands remain
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic  exec;
    ctrl_t word;
  } seq_ctrl_t;

  // The microprogram: one band pass is steps 1 to 7, repeated per band.
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_OUT, src: SRC_X, coef: C_B0, first: 1'b0, loop: 1'b0, target: '0};
    unique case (step)
      4'd0: w.op = OP_INIT;
      4'd1: begin w.op = OP_MAC; w.src = SRC_X;  w.coef = C_B0; w.first = 1'b1; end
      4'd2: begin w.op = OP_MAC; w.src = SRC_X1; w.coef = C_B1; end
      4'd3: begin w.op = OP_MAC; w.src = SRC_X2; w.coef = C_B2; end
      4'd4: begin w.op = OP_MAC; w.src = SRC_Y1; w.coef = C_A1; end
      4'd5: begin w.op = OP_MAC; w.src = SRC_Y2; w.coef = C_A2; end
      4'd6: w.op = OP_SAT;
      4'd7: begin
        w.op = OP_GAIN; w.src = SRC_YN; w.coef = C_GAIN;
        w.loop = 1'b1; w.target = STEP_BAND_START;
      end
      default: w.op = OP_OUT;
    endcase
    return w;
  endfunction

  // Clamp to the Q1.28 range of the Q6.28 accumulator and take the Q1.15 part (floor shift by 13).
  function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v > ACC_MAX) c = ACC_MAX;
    else if (v < ACC_MIN) c = ACC_MIN;
    else c = v;
    return c[SAT_SHIFT+SAMPLE_W-1:SAT_SHIFT];
  endfunction

endpackage

### rtl/pbeq_sequencer.sv
// Microprogram sequencer: step counter, band counter and looping jump.
// Depends on pbeq_pkg for the control word and the program table.
module pbeq_sequencer #(
  parameter int BANDS  = 2,
  parameter int BAND_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       out_free,
  output logic                       ready,
  output pbeq_pkg::seq_ctrl_t        seq,
  output logic [BAND_W-1:0]          band
);
  import pbeq_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  ctrl_t             word;
  logic              is_out;
  logic              last_band;

  assign word      = rom_word(step);
  assign is_out    = (word.op == OP_OUT);
  assign ready     = !busy || (is_out && out_free);
  assign seq.exec  = busy && (!is_out || out_free);
  assign seq.word  = word;
  assign last_band = (band == BAND_W'(BANDS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      band <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      band <= '0;
    end else if (seq.exec) begin
      if (is_out) begin
        busy <= 1'b0;
      end else if (word.loop && !last_band) begin
        band <= band + BAND_W'(1);
        step <= word.target;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

endmodule

### rtl/pbeq_datapath.sv
// Shared multiply-accumulate datapath with the filter delay lines.
// Depends on pbeq_pkg; driven by pbeq_sequencer control words.
module pbeq_datapath #(
  parameter int BANDS  = 2,
  parameter int BAND_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic signed [pbeq_pkg::SAMPLE_W-1:0]  sample_in,
  input  pbeq_pkg::seq_ctrl_t                   seq,
  input  logic [BAND_W-1:0]                     band,
  input  pbeq_pkg::cfg_bank_t                   cfg,
  output logic signed [pbeq_pkg::SAMPLE_W-1:0]  sample_out
);
  import pbeq_pkg::*;

  logic signed [SAMPLE_W-1:0]   x_reg;
  logic signed [SAMPLE_W-1:0]   x1;
  logic signed [SAMPLE_W-1:0]   x2;
  logic signed [SAMPLE_W-1:0]   y_new;
  logic signed [SAMPLE_W-1:0]   y1_arr [BANDS];
  logic signed [SAMPLE_W-1:0]   y2_arr [BANDS];
  logic signed [ACC_W-1:0]      z_acc;
  logic signed [ACC_W-1:0]      total;

  logic [CFG_W-1:0]             ff;
  logic [CFG_W-1:0]             fb;
  logic signed [SAMPLE_W-1:0]   opa;
  logic signed [SAMPLE_W-1:0]   opc;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic signed [ACC_W-1:0]      prod_ext;
  logic signed [ACC_W-1:0]      mac_term;
  logic signed [ACC_W-1:0]      gain_term;
  logic signed [SAMPLE_W-1:0]   z_sat;

  // Bands beyond the register set see all-zero coefficients.
  always_comb begin
    ff = '0;
    fb = '0;
    for (int i = 0; i < CFG_BANDS; i++) begin
      if (32'(band) == i) begin
        ff = cfg[2*i];
        fb = cfg[2*i+1];
      end
    end
  end

  always_comb begin
    unique case (seq.word.src)
      SRC_X:   opa = x_reg;
      SRC_X1:  opa = x1;
      SRC_X2:  opa = x2;
      SRC_Y1:  opa = y1_arr[band];
      SRC_Y2:  opa = y2_arr[band];
      SRC_YN:  opa = y_new;
      default: opa = '0;
    endcase
  end

  always_comb begin
    unique case (seq.word.coef)
      C_B0:    opc = $signed(ff[15:0]);
      C_B1:    opc = $signed(ff[31:16]);
      C_B2:    opc = $signed(ff[47:32]);
      C_A1:    opc = $signed(fb[15:0]);
      C_A2:    opc = $signed(fb[31:16]);
      C_GAIN:  opc = $signed(fb[47:32]);
      default: opc = '0;
    endcase
  end

  assign prod      = opa * opc;
  assign prod_ext  = ACC_W'(prod);
  assign mac_term  = prod_ext >>> 1;
  assign gain_term = prod_ext >>> 2;
  assign z_sat     = sat_q15(z_acc);

  // Filter state: reset to zero as the delay lines start silent.
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      for (int i = 0; i < BANDS; i++) begin
        y1_arr[i] <= '0;
        y2_arr[i] <= '0;
      end
    end else if (seq.exec) begin
      if (seq.word.op == OP_SAT) begin
        y2_arr[band] <= y1_arr[band];
        y1_arr[band] <= z_sat;
      end
      if (seq.word.op == OP_OUT) begin
        x2 <= x1;
        x1 <= x_reg;
      end
    end
  end

  // Working registers carry payload only and need no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      x_reg <= sample_in;
    end
    if (seq.exec) begin
      unique case (seq.word.op)
        OP_INIT: total <= ACC_W'(x_reg) <<< SAT_SHIFT;
        OP_MAC:  z_acc <= seq.word.first ? mac_term : z_acc + mac_term;
        OP_SAT:  y_new <= z_sat;
        OP_GAIN: total <= total + gain_term;
        OP_OUT:  sample_out <= sat_q15(total);
        default: ;
      endcase
    end
  end

endmodule

### rtl/parallel_biquad_equalizer_q15.sv
// Top level of the parallel biquad equaliser: handshakes and coefficient registers.
// Depends on pbeq_pkg, pbeq_sequencer and pbeq_datapath.

// A sample is taken on each input transfer and one equalised sample leaves on an
// output transfer for every sample taken. All bands filter the same input with a
// single shared 16 by 16 multiplier, stepped by a small microprogram: one set-up
// step, seven steps per band (five filter taps, saturation, gain) and one step to
// write the result. The next sample may be transferred in during the write step
// of the previous one. A finished result sits in an output register; while it
// waits to be taken, a new sample is still accepted and worked on, and only the
// final write step pauses until the register is free. Coefficients are written
// through a plain write port and must only change while the block is idle;
// writes to an index beyond the four registers are ignored. Bands beyond the
// second have no registers and contribute nothing to the result.
module parallel_biquad_equalizer_q15 #(
  parameter int BANDS = 2
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [pbeq_pkg::SAMPLE_W-1:0]    sample_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [pbeq_pkg::SAMPLE_W-1:0]    sample_out,
  input  logic                                    cfg_write,
  input  logic [pbeq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pbeq_pkg::CFG_W-1:0]              cfg_data
);
  import pbeq_pkg::*;

  localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;

  cfg_bank_t         cfg_regs;
  seq_ctrl_t         seq;
  logic [BAND_W-1:0] band;
  logic              ready;
  logic              start;
  logic              out_free;

  assign in_stall = !ready;
  assign start    = in_valid && ready;
  // The output register may be reloaded when empty or when its contents leave now.
  assign out_free = !out_valid || !out_stall;

  // Coefficient registers; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg_write && (cfg_index < CFG_IDX_W'(CFG_REGS))) begin
      cfg_regs[cfg_index[$clog2(CFG_REGS)-1:0]] <= cfg_data;
    end
  end

  // The valid flag follows the write step of the microprogram and each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq.exec && (seq.word.op == OP_OUT)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  pbeq_sequencer #(
    .BANDS  (BANDS),
    .BAND_W (BAND_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .ready    (ready),
    .seq      (seq),
    .band     (band)
  );

  pbeq_datapath #(
    .BANDS  (BANDS),
    .BAND_W (BAND_W)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .load       (start),
    .sample_in  (sample_in),
    .seq        (seq),
    .band       (band),
    .cfg        (cfg_regs),
    .sample_out (sample_out)
  );

endmodule

### rtl/pbeq_checker.sv
// Port-level checks of the equaliser's handshakes, bound to the top level.
// Depends on parallel_biquad_equalizer_q15_macros.svh and the top level's ports.
`include "parallel_biquad_equalizer_q15_macros.svh"

module pbeq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] sample_out
);

  `PBEQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out), "stalled result changed")
  `PBEQ_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input taken while a sample is in work")
  // A rise of the valid flag comes from a write step, which never directly follows an input transfer.
  `PBEQ_ASSERT_NOW(a_no_instant_out, $rose(out_valid), !$past(in_valid && !in_stall, 2), "early result")
  `PBEQ_ASSERT_NOW(a_out_from_work, $rose(out_valid), $past(in_stall, 2), "result appeared without a sample in work")

endmodule

bind parallel_biquad_equalizer_q15 pbeq_checker u_pbeq_checker (.*);
